// ----- rtl/mspc_pkg.sv -----
// Shared constants and codes for the multi-servo PWM controller.
// Holds field widths, command and status codes, register indexes and reset values.
// No dependencies; imported by multi_servo_pwm_controller_core.
package mspc_pkg;

    // slot table size and index width
    localparam int SLOTS    = 8;
    localparam int SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // field widths
    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 3;
    localparam int PIN_W    = 5;
    localparam int ANGLE_W  = 17;
    localparam int PULSE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int LINES_W  = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // stream packing
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = CMD_W;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = STATUS_W;

    // angle to pulse mapping arithmetic
    // product of clamped angle and pulse span, 17x17 signed
    localparam int PROD_W   = 34;
    // product shifted up so that floor division works on unsigned values
    localparam int BIASED_W = 34;
    // biased product divided by 16, the rest of 18000 is 1125
    localparam int MAG_W    = 30;
    localparam int RECIP_W  = 31;
    localparam int RECIP_SHIFT = 41;
    localparam int RPROD_W  = MAG_W + RECIP_W;
    localparam int QUO_W    = 20;
    localparam int MAP_W    = 22;
    // ceil(2^41 / 1125), exact floor division for all 30-bit dividends
    localparam logic [RECIP_W-1:0]  RECIP      = 31'd1954687339;
    // bias is BIAS_STEPS * 18000, larger than any negative product
    localparam int                  BIAS_STEPS = 238610;
    localparam logic [BIASED_W-1:0] BIAS       = 34'd4294980000;

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // command codes
    localparam cmd_t CMD_ATTACH      = 3'd0;
    localparam cmd_t CMD_WRITE_ANGLE = 3'd1;
    localparam cmd_t CMD_WRITE_US    = 3'd2;
    localparam cmd_t CMD_DETACH      = 3'd3;
    localparam cmd_t CMD_TICK        = 3'd4;

    // status codes
    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_FULL       = 2'd1;
    localparam status_t ST_BAD_HANDLE = 2'd2;
    localparam status_t ST_UNATTACHED = 2'd3;

    // configuration register indexes
    localparam cfg_idx_t CFG_MIN_PULSE = 3'd0;
    localparam cfg_idx_t CFG_MAX_PULSE = 3'd1;
    localparam cfg_idx_t CFG_MIN_ANGLE = 3'd2;
    localparam cfg_idx_t CFG_MAX_ANGLE = 3'd3;
    localparam cfg_idx_t CFG_PERIOD    = 3'd4;

    // configuration reset values
    localparam logic [CFG_W-1:0] MIN_PULSE_RST = 16'd1000;
    localparam logic [CFG_W-1:0] MAX_PULSE_RST = 16'd2000;
    localparam logic [CFG_W-1:0] MIN_ANGLE_RST = 16'd0;
    localparam logic [CFG_W-1:0] MAX_ANGLE_RST = 16'd18000;
    localparam logic [CFG_W-1:0] PERIOD_RST    = 16'd20000;

endpackage

// ----- rtl/multi_servo_pwm_controller_core.sv -----
// Servo slot table with one PWM line per slot, advanced by a tick command.
// Three-stage pipeline: angle clamp and multiply, reciprocal divide, slot table update.
// Depends on mspc_pkg.
//
//  channel   group            payload
//  --------  ---------------  -------------------------------------------------------
//  input     s_tvalid/tready  tuser: command; tdata: slot, pin, angle, pulse width
//  result    m_tvalid/tready  tuser: status; tdata: slot, pin, level, lines, count
//  config    cfg_wr_en        cfg_addr selects the register, cfg_wdata is the value
//
// One transaction per cycle sustained while m_tready stays high; a result passes through the
// stage A, stage B and result registers and can be taken at the next edge.
// The first two stages depend only on the input and the configuration; all slot
// table and period counter state is read and written in the third stage only.
// Each stage holds while the stage after it is full and stalled, so empty stages
// still fill while a result waits on m_tready.
// Reset clears all valid bits, the slot table and the counter, and restores the
// configuration registers to their defaults.
module multi_servo_pwm_controller_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input transactions
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] slot, [7:3] pin, [24:8] angle_centideg, [40:25] pulse_width, rest zero
    input  logic [mspc_pkg::S_DATA_W-1:0]  s_tdata,
    // [2:0] command
    input  logic [mspc_pkg::S_USER_W-1:0]  s_tuser,
    // result transactions
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] slot_out, [7:3] pin_out, [23:8] level_out, [31:24] pwm_lines,
    // [47:32] period_count
    output logic [mspc_pkg::M_DATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [mspc_pkg::M_USER_W-1:0]  m_tuser,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [mspc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [mspc_pkg::CFG_W-1:0]     cfg_wdata
);
    import mspc_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] min_pulse_reg;
    logic [CFG_W-1:0] max_pulse_reg;
    logic [CFG_W-1:0] min_angle_reg;
    logic [CFG_W-1:0] max_angle_reg;
    logic [CFG_W-1:0] period_reg;

    // stage A: clamped angle times pulse span
    logic                       a_valid_reg;
    cmd_t                       a_cmd_reg;
    logic [SLOT_W-1:0]          a_slot_reg;
    logic [PIN_W-1:0]           a_pin_reg;
    logic [PULSE_W-1:0]         a_pw_reg;
    logic [PROD_W-1:0]          a_prod_reg;
    logic [PROD_W-1:0]          a_prod_next;

    // stage B: floor quotient of biased product
    logic                       b_valid_reg;
    cmd_t                       b_cmd_reg;
    logic [SLOT_W-1:0]          b_slot_reg;
    logic [PIN_W-1:0]           b_pin_reg;
    logic [PULSE_W-1:0]         b_pw_reg;
    logic [QUO_W-1:0]           b_quot_reg;
    logic [QUO_W-1:0]           b_quot_next;

    // slot table and period counter
    logic [SLOTS-1:0]           used_reg, used_next;
    logic [PIN_W-1:0]           pin_reg   [SLOTS];
    logic [PIN_W-1:0]           pin_next  [SLOTS];
    logic [PULSE_W-1:0]         level_reg [SLOTS];
    logic [PULSE_W-1:0]         level_next[SLOTS];
    logic [PULSE_W-1:0]         tick_reg, tick_next;

    // result register
    logic                       m_valid_reg;
    logic [M_DATA_W-1:0]        m_data_reg, m_data_next;
    logic [M_USER_W-1:0]        m_user_reg, m_user_next;

    // handshake
    logic a_ready, b_ready, s_fire, a_move, b_fire;

    // input field views
    cmd_t                       in_cmd;
    logic [SLOT_W-1:0]          in_slot;
    logic [PIN_W-1:0]           in_pin;
    logic [ANGLE_W-1:0]         in_angle;
    logic [PULSE_W-1:0]         in_pw;

    // stage A logic
    logic signed [ANGLE_W:0]    ang_ext, min_ext, max_ext, ang_lo, ang_clamp;
    logic signed [ANGLE_W-1:0]  ang_final;
    logic signed [ANGLE_W-1:0]  span;

    // stage B logic
    logic [BIASED_W-1:0]        biased;
    logic [MAG_W-1:0]           mag;
    logic [RPROD_W-1:0]         rprod;

    // stage C logic
    logic signed [MAP_W-1:0]    mapped;
    logic [PULSE_W-1:0]         mapped_sat;
    logic [PULSE_W-1:0]         angle_level;
    logic [PULSE_W-1:0]         us_level;
    logic                       free_found;
    logic [SlotIdxW-1:0]        free_idx;
    logic [SlotIdxW-1:0]        slot_idx;
    logic                       bad_handle;
    logic [PULSE_W:0]           tick_inc;
    status_t                    res_status;
    logic [SLOT_W-1:0]          res_slot;
    logic [PIN_W-1:0]           res_pin;
    logic [PULSE_W-1:0]         res_level;
    logic [LINES_W-1:0]         res_lines;

    // clamp a pulse to the configured limits, lower bound first
    function automatic logic [PULSE_W-1:0] clamp_pulse(
        input logic [PULSE_W-1:0] p,
        input logic [CFG_W-1:0]   lo,
        input logic [CFG_W-1:0]   hi
    );
        logic [PULSE_W-1:0] r;
        r = (p < lo) ? lo : p;
        r = (r > hi) ? hi : r;
        return r;
    endfunction

    // pipeline handshake
    assign b_ready  = !m_valid_reg || m_tready;
    assign a_ready  = !b_valid_reg || b_ready;
    assign s_tready = !a_valid_reg || a_ready;
    assign s_fire   = s_tvalid && s_tready;
    assign a_move   = a_valid_reg && a_ready;
    assign b_fire   = b_valid_reg && b_ready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // unpack input transaction
    assign in_cmd   = s_tuser;
    assign in_slot  = s_tdata[2:0];
    assign in_pin   = s_tdata[7:3];
    assign in_angle = s_tdata[24:8];
    assign in_pw    = s_tdata[40:25];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            min_angle_reg <= MIN_ANGLE_RST;
            max_angle_reg <= MAX_ANGLE_RST;
            period_reg    <= PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MIN_PULSE: min_pulse_reg <= cfg_wdata;
                CFG_MAX_PULSE: max_pulse_reg <= cfg_wdata;
                CFG_MIN_ANGLE: min_angle_reg <= cfg_wdata;
                CFG_MAX_ANGLE: max_angle_reg <= cfg_wdata;
                CFG_PERIOD:    period_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage A: angle clamp (attach uses angle zero) and multiply by pulse span
    always_comb begin
        ang_ext   = (in_cmd == CMD_ATTACH) ? '0 : {in_angle[ANGLE_W-1], in_angle};
        min_ext   = {{(ANGLE_W + 1 - CFG_W){min_angle_reg[CFG_W-1]}}, min_angle_reg};
        max_ext   = {{(ANGLE_W + 1 - CFG_W){1'b0}}, max_angle_reg};
        ang_lo    = (ang_ext < min_ext) ? min_ext : ang_ext;
        ang_clamp = (ang_lo > max_ext) ? max_ext : ang_lo;
        ang_final = ang_clamp[ANGLE_W-1:0];
        span      = {1'b0, max_pulse_reg} - {1'b0, min_pulse_reg};
        a_prod_next = PROD_W'(PROD_W'(ang_final) * PROD_W'(span));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
        if (s_fire) begin
            a_cmd_reg  <= in_cmd;
            a_slot_reg <= in_slot;
            a_pin_reg  <= in_pin;
            a_pw_reg   <= in_pw;
            a_prod_reg <= a_prod_next;
        end
    end

    // stage B: floor(product / 18000) + bias steps via shift and reciprocal
    always_comb begin
        biased      = a_prod_reg + BIAS;
        mag         = biased[BIASED_W-1:BIASED_W-MAG_W];
        rprod       = RPROD_W'(mag) * RPROD_W'(RECIP);
        b_quot_next = rprod[RECIP_SHIFT +: QUO_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (a_move) begin
            b_cmd_reg  <= a_cmd_reg;
            b_slot_reg <= a_slot_reg;
            b_pin_reg  <= a_pin_reg;
            b_pw_reg   <= a_pw_reg;
            b_quot_reg <= b_quot_next;
        end
    end

    // stage C: remove bias, add minimum pulse, saturate and clamp
    always_comb begin
        mapped = MAP_W'($signed({2'b00, b_quot_reg})) - MAP_W'(BIAS_STEPS)
               + MAP_W'($signed({6'b000000, min_pulse_reg}));
        if (mapped < 0) begin
            mapped_sat = '0;
        end else if (mapped > MAP_W'($signed({6'b000000, {PULSE_W{1'b1}}}))) begin
            mapped_sat = '1;
        end else begin
            mapped_sat = mapped[PULSE_W-1:0];
        end
        angle_level = clamp_pulse(mapped_sat, min_pulse_reg, max_pulse_reg);
        us_level    = clamp_pulse(b_pw_reg, min_pulse_reg, max_pulse_reg);
    end

    // first free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!free_found && !used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SlotIdxW'(i);
            end
        end
    end

    assign slot_idx   = SlotIdxW'(b_slot_reg);
    assign bad_handle = (int'(b_slot_reg) >= SLOTS);
    assign tick_inc   = {1'b0, tick_reg} + (PULSE_W + 1)'(1);

    // slot table update and result fields
    always_comb begin
        used_next  = used_reg;
        pin_next   = pin_reg;
        level_next = level_reg;
        tick_next  = tick_reg;
        res_status = ST_OK;
        res_slot   = '0;
        res_pin    = '0;
        res_level  = '0;
        unique case (b_cmd_reg)
            CMD_ATTACH: begin
                if (free_found) begin
                    used_next[free_idx]  = 1'b1;
                    pin_next[free_idx]   = b_pin_reg;
                    level_next[free_idx] = angle_level;
                    res_slot  = SLOT_W'(free_idx);
                    res_pin   = b_pin_reg;
                    res_level = angle_level;
                end else begin
                    res_status = ST_FULL;
                end
            end
            CMD_WRITE_ANGLE, CMD_WRITE_US, CMD_DETACH: begin
                res_slot = b_slot_reg;
                if (bad_handle) begin
                    res_status = ST_BAD_HANDLE;
                end else if (!used_reg[slot_idx]) begin
                    res_status = ST_UNATTACHED;
                    res_pin    = pin_reg[slot_idx];
                    res_level  = level_reg[slot_idx];
                end else begin
                    res_pin = pin_reg[slot_idx];
                    if (b_cmd_reg == CMD_WRITE_ANGLE) begin
                        level_next[slot_idx] = angle_level;
                        res_level = angle_level;
                    end else if (b_cmd_reg == CMD_WRITE_US) begin
                        level_next[slot_idx] = us_level;
                        res_level = us_level;
                    end else begin
                        used_next[slot_idx]  = 1'b0;
                        level_next[slot_idx] = '0;
                    end
                end
            end
            CMD_TICK: begin
                tick_next = (tick_inc >= {1'b0, period_reg}) ? '0 : tick_inc[PULSE_W-1:0];
            end
            default: ;
        endcase
    end

    // pwm lines from the updated table and counter
    always_comb begin
        res_lines = '0;
        for (int i = 0; i < LINES_W; i++) begin
            if (i < SLOTS) begin
                res_lines[i] = used_next[i] && (tick_next < level_next[i]);
            end
        end
        m_data_next = {tick_next, res_lines, res_level, res_pin, res_slot};
        m_user_next = res_status;
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                pin_reg[i]   <= '0;
                level_reg[i] <= '0;
            end
        end else begin
            if (b_ready) begin
                m_valid_reg <= b_valid_reg;
            end
            if (b_fire) begin
                used_reg  <= used_next;
                pin_reg   <= pin_next;
                level_reg <= level_next;
                tick_reg  <= tick_next;
            end
        end
        if (b_fire) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

endmodule
